// ===== rtl/gb_pkg.sv =====
// ----------------------------------------------------------------------------
// gb_pkg
// Shared types and constants for the streaming Gaussian blur.
// ----------------------------------------------------------------------------
package gb_pkg;

   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int WT_W       = 16;
   localparam int PROD_W     = CH_W + WT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MAX_HEIGHT   = 4096;
   localparam int ROW_W        = 12;
   localparam int FRAC_SHIFT   = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_ONE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_TWO    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_THREE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;

   // reset values
   localparam logic [WT_W-1:0]         RST_WEIGHT_CENTER = 16'd26154;
   localparam logic [WT_W-1:0]         RST_WEIGHT_ONE    = 16'd15862;
   localparam logic [WT_W-1:0]         RST_WEIGHT_TWO    = 16'd3539;
   localparam logic [WT_W-1:0]         RST_WEIGHT_THREE  = 16'd290;
   localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;

   localparam int MODE_PIXEL = 0;
   localparam int MODE_FLUSH = 1;

   typedef logic [NUM_CH-1:0][CH_W-1:0]   pix_type;
   typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_type;

   typedef struct packed {
      logic shift;
      logic mul;
   } cell_ctrl_type;

endpackage

// ===== rtl/gb_ram.sv =====
// ----------------------------------------------------------------------------
// gb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 6151
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gb_cell.sv =====
// ----------------------------------------------------------------------------
// gb_cell
// One tap of the horizontal chain: holds a pixel, passes it on, weights it.
// ----------------------------------------------------------------------------
module gb_cell (
   input  logic                      clock,
   input  gb_pkg::cell_ctrl_type     ctrl,
   input  gb_pkg::pix_type           pix_in,
   input  logic [gb_pkg::WT_W-1:0]   weight,
   output gb_pkg::pix_type           pix_out,
   output gb_pkg::prod_type          prod
);

   gb_pkg::pix_type  pix_ff;
   gb_pkg::prod_type prod_ff;
   gb_pkg::prod_type prod_in;

   always_comb begin
      for (int ch = 0; ch < gb_pkg::NUM_CH; ch++) begin
         prod_in[ch] = gb_pkg::PROD_W'(weight) * gb_pkg::PROD_W'(pix_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         pix_ff <= pix_in;
      end
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign pix_out = pix_ff;
   assign prod    = prod_ff;

endmodule

// ===== rtl/gaussian_blur_clamped_edge.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_clamped_edge
// Streaming separable Gaussian blur with clamp-to-edge borders.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order (req_mode 0), flush ticks
// (req_mode 1) drain the tail of a frame. Results leave on the rsp_ channel,
// lagging the input by MAX_RADIUS rows plus MAX_RADIUS pixels. csr_ writes
// set the four 1D weights and the image geometry; a geometry write restarts
// the frame. Configure only while the block is idle.
// An item that produces no result goes back to idle after the backlog check.
// An item that produces a result runs the tap fetch loop: one line store read
// per tap, then one multiply/sum pass per kernel row through the cell chain
// and the vertical multiplier. No new item is taken until the item is done.
// The result sits in an output register; the next item is taken while it
// waits, and a new result holds until rsp_ready takes the old one.
// Reset clears counters, backlog and rsp_valid and loads default weights and
// 640x480 geometry; the line store needs no clearing.
// ----------------------------------------------------------------------------
module gaussian_blur_clamped_edge #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [gb_pkg::CH_W-1:0]           req_red_in,
   input  logic [gb_pkg::CH_W-1:0]           req_green_in,
   input  logic [gb_pkg::CH_W-1:0]           req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gb_pkg::CH_W-1:0]           rsp_red_out,
   output logic [gb_pkg::CH_W-1:0]           rsp_green_out,
   output logic [gb_pkg::CH_W-1:0]           rsp_blue_out,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gb_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DIAM  = 2 * MAX_RADIUS + 1;
   localparam int RING  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int RA_W  = $clog2(RING);
   localparam int SA_W  = RA_W + 2;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int EH_W  = gb_pkg::HEIGHT_REG_W;
   localparam int ROW_W = gb_pkg::ROW_W;
   localparam int S_W   = ((EH_W > EW_W) ? EH_W : EW_W) + 2;
   localparam int BL_W  = $clog2(RING + 1);
   localparam int CMP_W = ROW_W + EW_W + 1;
   localparam int DC_W  = $clog2(DIAM);
   localparam int WI_W  = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;
   localparam int RS_W  = gb_pkg::PROD_W + $clog2(DIAM);
   localparam int VP_W  = RS_W + gb_pkg::WT_W;
   localparam int ACC_W = VP_W + $clog2(DIAM);
   localparam logic signed [SA_W-1:0] RING_S = SA_W'(RING);
   localparam int NUM_CH_C = gb_pkg::NUM_CH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_ROW, ST_TAP, ST_DRAIN,
      ST_MUL, ST_SUM, ST_VMUL, ST_VACC, ST_EMIT
   } state_type;

   function automatic logic [RA_W-1:0] wrap_addr(input logic signed [SA_W-1:0] a);
      logic signed [SA_W-1:0] t;
      if (a < 0) begin
         t = a + RING_S;
      end else if (a >= RING_S) begin
         t = a - RING_S;
      end else begin
         t = a;
      end
      return t[RA_W-1:0];
   endfunction

   // control state
   state_type                          state_ff, state_in;
   logic [gb_pkg::WT_W-1:0]            wc_ff, wc_in, w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   logic [gb_pkg::WIDTH_REG_W-1:0]     width_ff, width_in;
   logic [gb_pkg::HEIGHT_REG_W-1:0]    height_ff, height_in;
   logic [COL_W-1:0]                   in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]                   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RA_W-1:0]                    wp_ff, wp_in;
   logic [BL_W-1:0]                    backlog_ff, backlog_in;
   logic [DC_W-1:0]                    dy_cnt_ff, dy_cnt_in, dx_cnt_ff, dx_cnt_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [RA_W-1:0]                    out_pos_ff, out_pos_in;
   logic [RA_W-1:0]                    row_addr_ff, row_addr_in;
   logic [NUM_CH_C-1:0][RS_W-1:0]      rowsum_ff, rowsum_in;
   logic [NUM_CH_C-1:0][VP_W-1:0]      vprod_ff, vprod_in;
   logic [NUM_CH_C-1:0][ACC_W-1:0]     acc_ff, acc_in;
   gb_pkg::pix_type                    rsp_pix_ff, rsp_pix_in;
   logic                               rsp_end_ff, rsp_end_in;

   // geometry and weights
   logic [EW_W-1:0]                    w_eff;
   logic [EH_W-1:0]                    h_eff;
   logic [gb_pkg::WT_W-1:0]            wvec [MAX_RADIUS+1];

   // ram and cells
   logic                               ram_wr_en, ram_rd_en;
   logic [RA_W-1:0]                    ram_rd_addr;
   gb_pkg::pix_type                    ram_rd_data;
   gb_pkg::pix_type                    chain [DIAM];
   gb_pkg::prod_type                   prods [DIAM];
   gb_pkg::cell_ctrl_type              cell_ctrl;

   logic req_xfer, csr_xfer, rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid & req_ready;
   assign csr_xfer  = csr_valid & csr_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = EW_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = EW_W'(MAX_WIDTH);
      end else begin
         w_eff = EW_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = EH_W'(1);
      end else if (32'(height_ff) > 32'(gb_pkg::MAX_HEIGHT)) begin
         h_eff = EH_W'(gb_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // offsets above three carry no weight
   always_comb begin
      for (int d = 0; d <= MAX_RADIUS; d++) begin
         case (d)
            0:       wvec[d] = wc_ff;
            1:       wvec[d] = w1_ff;
            2:       wvec[d] = w2_ff;
            3:       wvec[d] = w3_ff;
            default: wvec[d] = '0;
         endcase
      end
   end

   gb_ram #(
      .WIDTH (gb_pkg::NUM_CH * gb_pkg::CH_W),
      .DEPTH (RING)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data ({req_blue_in, req_green_in, req_red_in}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cell_ctrl.shift = rd_vld_ff;
   assign cell_ctrl.mul   = (state_ff == ST_MUL);

   // first fetched tap ends up in the far cell
   for (genvar k = 0; k < DIAM; k++) begin : g_cell
      localparam int D = (k < MAX_RADIUS) ? (MAX_RADIUS - k) : (k - MAX_RADIUS);
      if (k == 0) begin : g_head
         gb_cell u_cell (
            .clock   (clock),
            .ctrl    (cell_ctrl),
            .pix_in  (ram_rd_data),
            .weight  (wvec[D]),
            .pix_out (chain[k]),
            .prod    (prods[k])
         );
      end else begin : g_body
         gb_cell u_cell (
            .clock   (clock),
            .ctrl    (cell_ctrl),
            .pix_in  (chain[k-1]),
            .weight  (wvec[D]),
            .pix_out (chain[k]),
            .prod    (prods[k])
         );
      end
   end

   // next-state logic
   logic [EW_W-1:0]          col_inc;
   logic [EH_W-1:0]          row_inc;
   logic [CMP_W-1:0]         in_idx, lag, bl_c;
   logic signed [S_W-1:0]    dy_s, dx_s, rr, cc, hmax, wmax, dyc, dxc;
   logic signed [2*S_W-1:0]  row_off;
   logic [DC_W-1:0]          dy_abs;
   logic [gb_pkg::WT_W-1:0]  wy;
   logic [ACC_W:0]           rounded;
   logic [ACC_W:0]           scaled;

   always_comb begin
      state_in     = state_ff;
      wc_in        = wc_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      wp_in        = wp_ff;
      backlog_in   = backlog_ff;
      dy_cnt_in    = dy_cnt_ff;
      dx_cnt_in    = dx_cnt_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_pos_in   = out_pos_ff;
      row_addr_in  = row_addr_ff;
      rowsum_in    = rowsum_ff;
      vprod_in     = vprod_ff;
      acc_in       = acc_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_end_in   = rsp_end_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      rounded      = '0;
      scaled       = '0;

      in_idx = CMP_W'(in_row_ff) * CMP_W'(w_eff) + CMP_W'(in_col_ff);
      lag    = CMP_W'(MAX_RADIUS) * CMP_W'(w_eff) + CMP_W'(MAX_RADIUS);
      bl_c   = CMP_W'(backlog_ff);

      // row offset for the current kernel row, clamped to the image
      dy_s = $signed(S_W'(dy_cnt_ff)) - $signed(S_W'(MAX_RADIUS));
      rr   = $signed(S_W'(out_row_ff)) + dy_s;
      hmax = $signed(S_W'(h_eff)) - $signed(S_W'(1));
      if (rr < 0) begin
         rr = '0;
      end
      if (rr > hmax) begin
         rr = hmax;
      end
      dyc     = rr - $signed(S_W'(out_row_ff));
      row_off = (2*S_W)'(dyc) * $signed((2*S_W)'(w_eff));

      dx_s = $signed(S_W'(dx_cnt_ff)) - $signed(S_W'(MAX_RADIUS));
      cc   = $signed(S_W'(out_col_ff)) + dx_s;
      wmax = $signed(S_W'(w_eff)) - $signed(S_W'(1));
      if (cc < 0) begin
         cc = '0;
      end
      if (cc > wmax) begin
         cc = wmax;
      end
      dxc = cc - $signed(S_W'(out_col_ff));
      ram_rd_addr = wrap_addr($signed(SA_W'(row_addr_ff)) + SA_W'(dxc));

      dy_abs = (dy_cnt_ff >= DC_W'(MAX_RADIUS)) ? dy_cnt_ff - DC_W'(MAX_RADIUS)
                                                 : DC_W'(MAX_RADIUS) - dy_cnt_ff;
      wy = wvec[dy_abs[WI_W-1:0]];

      col_inc = EW_W'(in_col_ff) + EW_W'(1);
      row_inc = EH_W'(in_row_ff) + EH_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_mode == 1'(gb_pkg::MODE_PIXEL)) begin
                  ram_wr_en  = 1'b1;
                  wp_in      = (32'(wp_ff) == RING - 1) ? '0 : wp_ff + RA_W'(1);
                  backlog_in = backlog_ff + BL_W'(1);
                  if (col_inc >= w_eff) begin
                     in_col_in = '0;
                     in_row_in = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
                  end else begin
                     in_col_in = COL_W'(col_inc);
                  end
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (backlog_ff == '0 || (bl_c <= in_idx && bl_c <= lag)) begin
               state_in = ST_IDLE;
            end else begin
               out_pos_in = wrap_addr($signed(SA_W'(wp_ff)) - $signed(SA_W'(backlog_ff)));
               dy_cnt_in  = '0;
               acc_in     = '0;
               state_in   = ST_ROW;
            end
         end
         ST_ROW: begin
            row_addr_in = wrap_addr($signed(SA_W'(out_pos_ff)) + SA_W'(row_off));
            dx_cnt_in   = '0;
            state_in    = ST_TAP;
         end
         ST_TAP: begin
            ram_rd_en = 1'b1;
            rd_vld_in = 1'b1;
            dx_cnt_in = dx_cnt_ff + DC_W'(1);
            if (32'(dx_cnt_ff) == DIAM - 1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            for (int ch = 0; ch < NUM_CH_C; ch++) begin
               rowsum_in[ch] = '0;
               for (int k = 0; k < DIAM; k++) begin
                  rowsum_in[ch] = rowsum_in[ch] + RS_W'(prods[k][ch]);
               end
            end
            state_in = ST_VMUL;
         end
         ST_VMUL: begin
            for (int ch = 0; ch < NUM_CH_C; ch++) begin
               vprod_in[ch] = VP_W'(wy) * VP_W'(rowsum_ff[ch]);
            end
            state_in = ST_VACC;
         end
         ST_VACC: begin
            for (int ch = 0; ch < NUM_CH_C; ch++) begin
               acc_in[ch] = acc_ff[ch] + ACC_W'(vprod_ff[ch]);
            end
            dy_cnt_in = dy_cnt_ff + DC_W'(1);
            state_in  = (32'(dy_cnt_ff) == DIAM - 1) ? ST_EMIT : ST_ROW;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               for (int ch = 0; ch < NUM_CH_C; ch++) begin
                  rounded = (ACC_W+1)'(acc_ff[ch]) + ((ACC_W+1)'(1) << (gb_pkg::FRAC_SHIFT - 1));
                  scaled  = rounded >> gb_pkg::FRAC_SHIFT;
                  rsp_pix_in[ch] = (scaled > (ACC_W+1)'(255)) ? 8'hFF : scaled[7:0];
               end
               rsp_end_in = (EH_W'(out_row_ff) == h_eff - EH_W'(1)) &&
                            (EW_W'(out_col_ff) == w_eff - EW_W'(1));
               rsp_valid_in = 1'b1;
               backlog_in   = backlog_ff - BL_W'(1);
               if (EW_W'(out_col_ff) + EW_W'(1) >= w_eff) begin
                  out_col_in = '0;
                  out_row_in = (EH_W'(out_row_ff) + EH_W'(1) >= h_eff) ? '0
                               : out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_xfer) begin
         case (csr_index)
            gb_pkg::REG_WEIGHT_CENTER: wc_in = csr_data;
            gb_pkg::REG_WEIGHT_ONE:    w1_in = csr_data;
            gb_pkg::REG_WEIGHT_TWO:    w2_in = csr_data;
            gb_pkg::REG_WEIGHT_THREE:  w3_in = csr_data;
            gb_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_data[gb_pkg::WIDTH_REG_W-1:0];
            end
            gb_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_data[gb_pkg::HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
         // geometry change restarts the frame
         if (csr_index == gb_pkg::REG_IMAGE_WIDTH || csr_index == gb_pkg::REG_IMAGE_HEIGHT) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            backlog_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wc_ff        <= gb_pkg::RST_WEIGHT_CENTER;
         w1_ff        <= gb_pkg::RST_WEIGHT_ONE;
         w2_ff        <= gb_pkg::RST_WEIGHT_TWO;
         w3_ff        <= gb_pkg::RST_WEIGHT_THREE;
         width_ff     <= gb_pkg::RST_IMAGE_WIDTH;
         height_ff    <= gb_pkg::RST_IMAGE_HEIGHT;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         wp_ff        <= '0;
         backlog_ff   <= '0;
         dy_cnt_ff    <= '0;
         dx_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wc_ff        <= wc_in;
         w1_ff        <= w1_in;
         w2_ff        <= w2_in;
         w3_ff        <= w3_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         wp_ff        <= wp_in;
         backlog_ff   <= backlog_in;
         dy_cnt_ff    <= dy_cnt_in;
         dx_cnt_ff    <= dx_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_pos_ff  <= out_pos_in;
      row_addr_ff <= row_addr_in;
      rowsum_ff   <= rowsum_in;
      vprod_ff    <= vprod_in;
      acc_ff      <= acc_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff[0];
   assign rsp_green_out = rsp_pix_ff[1];
   assign rsp_blue_out  = rsp_pix_ff[2];
   assign rsp_frame_end = rsp_end_ff;

endmodule
